@@ rtl/lc3s_pkg.sv @@
// lc3s_pkg: shared types and constants of the lc3 subset core
// used by the controller, datapath and top level
`default_nettype none
package lc3s_pkg;
   localparam int MemWords = 256;
   localparam int AddrBits = $clog2(MemWords);

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_STEP    = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      OP_BR  = 4'd0,
      OP_ADD = 4'd1,
      OP_LD  = 4'd2,
      OP_AND = 4'd5,
      OP_LDR = 4'd6,
      OP_STR = 4'd7,
      OP_NOT = 4'd9,
      OP_LDI = 4'd10,
      OP_STI = 4'd11,
      OP_RSV = 4'd12,
      OP_TRP = 4'd15
   } opcode_type;

   localparam logic [7:0] TrapOut  = 8'd33;
   localparam logic [7:0] TrapHalt = 8'd37;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_DECODE,
      ST_MEM1,
      ST_MEM2,
      ST_MEM3,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // latch request
      logic       clear_wr;    // write zero at clear counter
      logic       do_load;
      logic       do_restart;
      logic       rd_pc;       // memory read at pc
      logic       exec;        // execute decoded instruction
      logic       rd_ea;       // memory access at effective address (STR writes)
      logic       rd_ind;      // memory read at fetched pointer
      logic       wb_mem;      // register write from memory data
      logic       st_ind;      // store to fetched pointer
      logic       respond;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clear_last;
      logic       runnable;
      opcode_type op;
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/lc3_subset_core.sv @@
// lc3_subset_core: top level of the lc3 subset processor
// depends on lc3s_pkg, lc3s_control, lc3s_datapath
//
// usage: drive req_action/req_address/req_data and raise start while busy
// is low; the request is taken at that edge. action 0 writes a memory word,
// 1 executes one instruction at the pc, 2 restarts at req_address.
// exactly one response per request appears on the rsp_ ports for a single
// cycle with rsp_valid high; the receiver cannot stall and must take it.
// a request passes fetch and done; a step that runs also passes decode, and
// LD, LDR, LDI, STR and STI then pass mem1, mem2 and mem3, before the
// registered response. busy is low in the response cycle, so the next
// request can be taken at the edge that ends it; a new request is not
// taken before the last one has its response.
// each memory access uses the single port of the word ram.
// after reset all 256 words of memory are swept to zero, one word a cycle,
// with busy high; registers then hold Rn = n, pc and flags zero.
`default_nettype none
module lc3_subset_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_address,
   input  wire logic [15:0] req_data,
   output logic             rsp_valid,
   output logic [15:0]      rsp_pc,
   output logic [15:0]      rsp_instruction,
   output logic [2:0]       rsp_flags,
   output logic             rsp_halted,
   output logic             rsp_char_valid,
   output logic [7:0]       rsp_char_out
);
   import lc3s_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lc3s_control u_control (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .stat(stat), .cmd(cmd), .busy(busy));

   lc3s_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_address(req_address), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_pc(rsp_pc), .rsp_instruction(rsp_instruction),
      .rsp_flags(rsp_flags), .rsp_halted(rsp_halted),
      .rsp_char_valid(rsp_char_valid), .rsp_char_out(rsp_char_out));

`ifndef ASSERT_OFF
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(!busy)) else $error("response without work");
   a_char_step: assert property (@(posedge clock) disable iff (reset)
      rsp_char_valid && rsp_valid |-> rsp_instruction[15:12] == OP_TRP)
      else $error("char without trap");
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after response");
`endif
endmodule
`default_nettype wire

@@ rtl/lc3s_ram.sv @@
// lc3s_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module lc3s_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/lc3s_datapath.sv @@
// lc3s_datapath: registers, pc, flags, memory and result registers
// depends on lc3s_pkg and lc3s_ram
`default_nettype none
module lc3s_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lc3s_pkg::cmd_type cmd,
   output lc3s_pkg::stat_type     stat,
   input  wire logic [15:0]       req_address,
   input  wire logic [15:0]       req_data,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_pc,
   output logic [15:0]            rsp_instruction,
   output logic [2:0]             rsp_flags,
   output logic                   rsp_halted,
   output logic                   rsp_char_valid,
   output logic [7:0]             rsp_char_out
);
   import lc3s_pkg::*;

   logic [15:0] addr_ff, data_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, pc_in;
   logic [15:0] ir_ff, ir_in;
   logic [15:0] ea_ff, ea_in;
   logic [2:0]  cc_ff, cc_in;
   logic        stop_ff, stop_in;
   logic        cv_ff, cv_in;
   logic [7:0]  ch_ff, ch_in;
   logic [AddrBits-1:0] clr_ff;
   logic        valid_ff;

   logic                mem_we;
   logic [AddrBits-1:0] mem_addr;
   logic [15:0]         mem_wd, mem_rd;

   lc3s_ram #(.Width(16), .Depth(MemWords)) u_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd), .rd_data(mem_rd));

   logic [15:0] ir_now, sr1v, bv, off9, off6, alu, wb_val;
   logic [2:0]  dr, sr1;
   logic        wb_en;
   logic [15:0] pc_plus;

   function automatic logic [2:0] nzp(input logic [15:0] v);
      if (v == 16'd0) return 3'b010;
      else if (v[15]) return 3'b100;
      else return 3'b001;
   endfunction

   // ir_now: the fetched word, held from decode on
   assign ir_now = cmd.exec ? mem_rd : ir_ff;
   assign dr   = ir_now[11:9];
   assign sr1  = ir_now[8:6];
   assign sr1v = regs_ff[sr1];
   assign off9 = {{7{ir_now[8]}}, ir_now[8:0]};
   assign off6 = {{10{ir_now[5]}}, ir_now[5:0]};
   assign bv   = ir_now[5] ? {{11{ir_now[4]}}, ir_now[4:0]} : regs_ff[ir_now[2:0]];
   assign pc_plus = pc_ff + off9;

   assign stat.clear_last = (clr_ff == AddrBits'(MemWords - 1));
   assign stat.runnable   = !stop_ff && ({16'd0, pc_ff} < 32'(MemWords));
   assign stat.op         = opcode_type'(mem_rd[15:12]);

   always_comb begin
      pc_in = pc_ff; ir_in = ir_ff; ea_in = ea_ff; cc_in = cc_ff;
      stop_in = stop_ff; cv_in = cv_ff; ch_in = ch_ff;
      wb_en = 1'b0; wb_val = mem_rd; alu = 16'd0;
      mem_we = 1'b0; mem_addr = pc_ff[AddrBits-1:0]; mem_wd = regs_ff[dr];
      if (cmd.capture) begin
         ir_in = 16'd0; cv_in = 1'b0; ch_in = 8'd0;
      end
      if (cmd.clear_wr) begin
         mem_we = 1'b1; mem_addr = clr_ff; mem_wd = 16'd0;
      end
      if (cmd.do_load) begin
         mem_we = 1'b1; mem_addr = addr_ff[AddrBits-1:0]; mem_wd = data_ff;
      end
      if (cmd.do_restart) begin
         pc_in = addr_ff; stop_in = 1'b0;
      end
      if (cmd.rd_pc) begin
         mem_addr = pc_ff[AddrBits-1:0];
      end
      if (cmd.exec) begin
         // pc_ff already incremented by the fetch step
         ir_in = mem_rd;
         unique case (opcode_type'(mem_rd[15:12]))
            OP_ADD: begin alu = sr1v + bv; wb_en = 1'b1; wb_val = alu; end
            OP_AND: begin alu = sr1v & bv; wb_en = 1'b1; wb_val = alu; end
            OP_NOT: begin alu = ~sr1v; wb_en = 1'b1; wb_val = alu; end
            OP_BR:  if ((dr & cc_ff) != 3'd0) pc_in = pc_plus;
            OP_LD, OP_LDI, OP_STI: ea_in = pc_plus;
            OP_LDR, OP_STR: ea_in = sr1v + off6;
            OP_TRP: begin
               if (mem_rd[7:0] == TrapHalt) stop_in = 1'b1;
               else if (mem_rd[7:0] == TrapOut) begin
                  cv_in = 1'b1; ch_in = regs_ff[0][7:0];
               end
            end
            default: ;
         endcase
      end
      if (cmd.rd_ea) begin
         mem_addr = ea_ff[AddrBits-1:0];
         if (opcode_type'(ir_ff[15:12]) == OP_STR) mem_we = 1'b1;
      end
      if (cmd.rd_ind) begin
         mem_addr = mem_rd[AddrBits-1:0];
         ea_in = mem_rd;
      end
      if (cmd.st_ind) begin
         mem_we = 1'b1; mem_addr = ea_ff[AddrBits-1:0];
      end
      if (cmd.wb_mem) begin
         wb_en = 1'b1; wb_val = mem_rd;
      end
      if (wb_en) cc_in = nzp(wb_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'(i);
         pc_ff <= 16'd0; cc_ff <= 3'd0; stop_ff <= 1'b0;
         clr_ff <= '0; valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            addr_ff <= req_address; data_ff <= req_data;
         end
         if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
         pc_ff <= cmd.rd_pc ? pc_ff + 16'd1 : pc_in;
         cc_ff <= cc_in; stop_ff <= stop_in;
         if (wb_en) regs_ff[cmd.wb_mem ? ir_ff[11:9] : dr] <= wb_val;
         valid_ff <= cmd.respond;
      end
      ir_ff <= ir_in; ea_ff <= ea_in; cv_ff <= cv_in; ch_ff <= ch_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pc          = pc_ff;
   assign rsp_instruction = ir_ff;
   assign rsp_flags       = cc_ff;
   assign rsp_halted      = !stat.runnable;
   assign rsp_char_valid  = cv_ff;
   assign rsp_char_out    = ch_ff;
endmodule
`default_nettype wire

@@ rtl/lc3s_control.sv @@
// lc3s_control: sequencer for request handling and instruction steps
// depends on lc3s_pkg
`default_nettype none
module lc3s_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_action,
   input  wire lc3s_pkg::stat_type stat,
   output lc3s_pkg::cmd_type       cmd,
   output logic                    busy
);
   import lc3s_pkg::*;

   state_type state_ff, state_in;
   action_type act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         act_ff   <= ACT_NONE;
      end else begin
         state_ff <= state_in;
         if (start && state_ff == ST_IDLE) act_ff <= action_type'(req_action);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_FETCH;
         ST_CLEAR:  if (stat.clear_last) state_in = ST_IDLE;
         ST_FETCH: begin
            if (act_ff == ACT_STEP && stat.runnable) state_in = ST_DECODE;
            else state_in = ST_DONE;
         end
         ST_DECODE: begin
            unique case (stat.op)
               OP_LD, OP_LDR, OP_LDI, OP_STI, OP_STR: state_in = ST_MEM1;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MEM1:   state_in = ST_MEM2;
         ST_MEM2:   state_in = ST_MEM3;
         ST_MEM3:   state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   opcode_type op_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECODE) op_ff <= stat.op;
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  cmd.capture = start;
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_FETCH: begin
            cmd.do_load    = (act_ff == ACT_LOAD);
            cmd.do_restart = (act_ff == ACT_RESTART);
            cmd.rd_pc      = (act_ff == ACT_STEP) && stat.runnable;
         end
         ST_DECODE: cmd.exec = 1'b1;
         // address phase: direct read or STR write
         ST_MEM1: cmd.rd_ea = 1'b1;
         ST_MEM2: begin
            // indirect ops chase the pointer, direct loads write back
            if (op_ff == OP_LDI || op_ff == OP_STI) cmd.rd_ind = 1'b1;
            else if (op_ff == OP_LD || op_ff == OP_LDR) cmd.wb_mem = 1'b1;
         end
         ST_MEM3: begin
            if (op_ff == OP_LDI) cmd.wb_mem = 1'b1;
            else if (op_ff == OP_STI) cmd.st_ind = 1'b1;
         end
         ST_DONE: cmd.respond = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire
